// File: rtl/assert_macros.svh
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the following cycle
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fssa_pkg.sv
`default_nettype none

package fssa_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned ADDR_W = 8;
  localparam int unsigned ACC_W  = 64 * 3 + 32;

  // luminance weights in Q0.16, they sum to one
  localparam logic [15:0] LUM_COEF_R = 16'd13937;
  localparam logic [15:0] LUM_COEF_G = 16'd46869;
  localparam logic [15:0] LUM_COEF_B = 16'd4730;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_TILE_X0  = 3'd0,
    CFG_TILE_Y0  = 3'd1,
    CFG_TILE_X1  = 3'd2,
    CFG_TILE_Y1  = 3'd3,
    CFG_RADIUS   = 3'd4,
    CFG_INV_RAD  = 3'd5,
    CFG_MAX_LUM  = 3'd6
  } cfg_idx_e;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RDOUT = 13'b0000000000010,
    S_LUM   = 13'b0000000000100,
    S_CHK   = 13'b0000000001000,
    S_CMUL  = 13'b0000000010000,
    S_DIV   = 13'b0000000100000,
    S_LW    = 13'b0000001000000,
    S_BND   = 13'b0000010000000,
    S_ROW   = 13'b0000100000000,
    S_COL   = 13'b0001000000000,
    S_RD    = 13'b0010000000000,
    S_MUL   = 13'b0100000000000,
    S_ADD   = 13'b1000000000000
  } fsm_state_e;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [31:0] s;
    s = a + b;
    if (a[31] == b[31] && s[31] != a[31]) begin
      s = a[31] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/fssa_cfg_if.sv
`default_nettype none

interface fssa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/fssa_smp_if.sv
`default_nettype none

interface fssa_smp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [19:0]        sample_x;
  logic [19:0]        sample_y;
  logic [31:0]        red;
  logic [31:0]        green;
  logic [31:0]        blue;
  logic [31:0]        sample_weight;
  logic [7:0]         table_index;
  logic signed [15:0] table_value;
  logic [7:0]         pixel_index;

  modport source (output valid, mode, sample_x, sample_y, red, green, blue, sample_weight,
                  table_index, table_value, pixel_index, input ready);
  modport sink (input valid, mode, sample_x, sample_y, red, green, blue, sample_weight,
                table_index, table_value, pixel_index, output ready);
endinterface

`default_nettype wire

// File: rtl/fssa_res_if.sv
`default_nettype none

interface fssa_res_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] sum_red;
  logic signed [63:0] sum_green;
  logic signed [63:0] sum_blue;
  logic signed [31:0] weight_sum;

  modport source (output valid, sum_red, sum_green, sum_blue, weight_sum, input ready);
  modport sink (input valid, sum_red, sum_green, sum_blue, weight_sum, output ready);
endinterface

`default_nettype wire

// File: rtl/fssa_ram.sv
`default_nettype none

module fssa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/filtered_sample_splat_accumulator_unit.sv
// Splat accumulator for one film tile. A request carries a mode: load one filter table word,
// add one sample, read one pixel's sums, or clear one pixel. Loads and clears are done as
// they are accepted; a read passes through a readout state and waits there on the result side
// (the result sits in an output register, so further requests are taken while it waits). An
// added sample is worked on alone through one shared 32x32 multiplier; its time grows with the
// rows and pixels of its clipped footprint, and a multiply and a bit-serial divide per channel
// are added when the luminance limit scales the colour. Each pixel is a read-modify-write of
// one wide accumulator memory entry (a table read and an entry read together, then the three
// colour products, then the saturating adds and write back); pixels are visited one after
// another, so no two accesses to one entry overlap. Accumulators read as zero after reset and
// after a clear, through one valid bit per pixel; no clearing pass is needed. Filter table
// entries are undefined until loaded.
`default_nettype none
`include "assert_macros.svh"

module filtered_sample_splat_accumulator_unit import fssa_pkg::*; #(
  parameter int unsigned TABLE_W = 16,
  parameter int unsigned TILE_W  = 16,
  parameter int unsigned TILE_H  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fssa_cfg_if.sink   cfg_i,
  fssa_smp_if.sink   smp_i,
  fssa_res_if.source res_o
);

  localparam int unsigned TW_W = (TABLE_W > 1) ? $clog2(TABLE_W) : 1;
  localparam logic [TW_W-1:0] TW_MAX = TW_W'(TABLE_W - 1);

  // state machine and counters
  fsm_state_e state_q, state_d;
  logic [1:0] k_q, k_d;          // channel counter
  logic [4:0] cnt_q, cnt_d;      // divider step

  // configuration registers
  logic [11:0] x0_q, y0_q, x1_q, y1_q;
  logic [31:0] rad_q, inv_q, maxlum_q;

  // sample data
  logic [19:0]        sx_q, sy_q;
  logic [31:0]        c_q [3];
  logic [31:0]        wgt_q;
  logic [47:0]        lum_acc_q;
  logic [31:0]        rem_q, quo_q;
  logic [63:0]        lw_q [3];
  logic signed [25:0] pdx_q, pdy_q;
  logic signed [15:0] xa_q, xb_q, ya_q, yb_q, x_q, y_q;
  logic [TW_W-1:0]    row_q, col_q;
  logic [ADDR_W-1:0]  pix_q;
  logic signed [63:0] con_q [3];

  // per-pixel valid bits, cleared entries read as zero
  logic [DEPTH-1:0] vld_q;
  logic             vld_rd_q;

  // result register
  logic               res_vld_q;
  logic signed [63:0] res_r_q, res_g_q, res_b_q;
  logic signed [31:0] res_w_q;

  logic acc_ok;
  assign acc_ok = smp_i.valid && smp_i.ready;
  assign smp_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // memories
  logic               tab_we;
  logic [ADDR_W-1:0]  tab_raddr;
  logic [15:0]        tab_rdata;
  logic               acc_we, acc_re;
  logic [ADDR_W-1:0]  acc_raddr;
  logic [ACC_W-1:0]   acc_wdata, acc_rdata;

  fssa_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (smp_i.table_index),
    .wdata_i (smp_i.table_value),
    .re_i    (state_q == S_RD),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  fssa_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (pix_q),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  assign tab_we    = acc_ok && (smp_i.mode == MODE_LOAD);
  assign acc_re    = (acc_ok && (smp_i.mode == MODE_READ)) || (state_q == S_RD);
  assign acc_raddr = (state_q == S_IDLE) ? smp_i.pixel_index : pix_q;
  assign acc_we    = (state_q == S_ADD);

  // shared multiplier: luminance terms, colour times limit, colour times weight
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [15:0] lum_coef;

  always_comb begin
    case (k_q)
      2'd0:    lum_coef = LUM_COEF_R;
      2'd1:    lum_coef = LUM_COEF_G;
      default: lum_coef = LUM_COEF_B;
    endcase
    case (state_q)
      S_LUM:   mul_b = {16'b0, lum_coef};
      S_CMUL:  mul_b = maxlum_q;
      default: mul_b = wgt_q;
    endcase
  end

  assign mul_p = 64'(c_q[k_q]) * 64'(mul_b);

  // luminance and clamp decision
  logic [31:0] lum;
  logic        clamp;
  assign lum   = lum_acc_q[47:16];
  assign clamp = (maxlum_q != '1) && (lum > maxlum_q);

  // one quotient bit per cycle, remainder stays below the luminance
  logic [32:0] div_r2, div_sub;
  logic        div_ge;
  logic [31:0] div_rem, div_quo;
  assign div_r2  = {rem_q, quo_q[31]};
  assign div_sub = div_r2 - {1'b0, lum};
  assign div_ge  = (div_r2 >= {1'b0, lum});
  assign div_rem = div_ge ? div_sub[31:0] : div_r2[31:0];
  assign div_quo = {quo_q[30:0], div_ge};

  // footprint bounds, position minus half a pixel in Q.12
  logic signed [25:0] pdx_c, pdy_c;
  logic signed [26:0] xlo, xhi, ylo, yhi, xa_s, xb_s, ya_s, yb_s;
  logic signed [15:0] xa_raw, xb_raw, ya_raw, yb_raw;
  logic signed [15:0] x0s, y0s, xes, yes, xa_c, xb_c, ya_c, yb_c;
  logic [12:0]        xe13, ye13;

  assign pdx_c = $signed({2'b0, sx_q, 4'b0}) - 26'sd2048;
  assign pdy_c = $signed({2'b0, sy_q, 4'b0}) - 26'sd2048;
  assign xlo   = 27'(pdx_c) - $signed({11'b0, rad_q[15:0]});
  assign xhi   = 27'(pdx_c) + $signed({11'b0, rad_q[15:0]});
  assign ylo   = 27'(pdy_c) - $signed({11'b0, rad_q[31:16]});
  assign yhi   = 27'(pdy_c) + $signed({11'b0, rad_q[31:16]});
  // ceil on the low side, floor plus one on the high side
  assign xa_s  = (xlo + 27'sd4095) >>> 12;
  assign ya_s  = (ylo + 27'sd4095) >>> 12;
  assign xb_s  = xhi >>> 12;
  assign yb_s  = yhi >>> 12;
  assign xa_raw = xa_s[15:0];
  assign ya_raw = ya_s[15:0];
  assign xb_raw = xb_s[15:0] + 16'sd1;
  assign yb_raw = yb_s[15:0] + 16'sd1;

  // end of tile clipped to the storage size
  assign xe13 = ((13'(x1_q)) > (13'(x0_q) + 13'(TILE_W))) ? (13'(x0_q) + 13'(TILE_W))
                                                          : 13'(x1_q);
  assign ye13 = ((13'(y1_q)) > (13'(y0_q) + 13'(TILE_H))) ? (13'(y0_q) + 13'(TILE_H))
                                                          : 13'(y1_q);
  assign x0s = $signed({4'b0, x0_q});
  assign y0s = $signed({4'b0, y0_q});
  assign xes = $signed({3'b0, xe13});
  assign yes = $signed({3'b0, ye13});
  assign xa_c = (xa_raw < x0s) ? x0s : xa_raw;
  assign ya_c = (ya_raw < y0s) ? y0s : ya_raw;
  assign xb_c = (xb_raw > xes) ? xes : xb_raw;
  assign yb_c = (yb_raw > yes) ? yes : yb_raw;

  // table slot from distance, shared between row and column
  logic signed [15:0] sl_pix;
  logic signed [25:0] sl_pd;
  logic [15:0]        sl_inv;
  logic signed [28:0] sl_d;
  logic [27:0]        sl_ad;
  logic [43:0]        sl_prod;
  logic [50:0]        sl_scl;
  logic [26:0]        sl_sh;
  logic [TW_W-1:0]    sl_idx;

  always_comb begin
    if (state_q == S_ROW) begin
      sl_pix = y_q;
      sl_pd  = pdy_q;
      sl_inv = inv_q[31:16];
    end else begin
      sl_pix = x_q;
      sl_pd  = pdx_q;
      sl_inv = inv_q[15:0];
    end
  end

  assign sl_d    = $signed({sl_pix[15], sl_pix, 12'b0}) - 29'(sl_pd);
  assign sl_ad   = sl_d[28] ? 28'(-sl_d) : sl_d[27:0];
  assign sl_prod = 44'(sl_ad) * 44'(sl_inv);
  assign sl_scl  = 51'(sl_prod) * 51'(TABLE_W);
  assign sl_sh   = sl_scl[50:24];
  assign sl_idx  = (sl_sh > 27'(TABLE_W - 1)) ? TW_MAX : sl_sh[TW_W-1:0];

  // tile local pixel and table address, both wrap to the storage depth
  logic [15:0] pix_tmp, tab_tmp;
  logic signed [15:0] ydiff, xdiff;
  assign ydiff     = y_q - y0s;
  assign xdiff     = x_q - x0s;
  assign pix_tmp   = 16'(ydiff) * 16'(TILE_W) + 16'(xdiff);
  assign tab_tmp   = 16'(row_q) * 16'(TABLE_W) + 16'(col_q);
  assign tab_raddr = tab_tmp[ADDR_W-1:0];

  // colour product times table weight, magnitude truncated then signed
  logic signed [15:0] tval;
  logic [15:0]        tmag;
  logic [79:0]        c_prod;
  logic [63:0]        c_mag;
  logic signed [63:0] con_c;
  assign tval   = tab_rdata;
  assign tmag   = tval[15] ? 16'(-tval) : tval;
  assign c_prod = 80'(lw_q[k_q]) * 80'(tmag);
  assign c_mag  = c_prod[79:16];
  assign con_c  = tval[15] ? -$signed(c_mag) : $signed(c_mag);

  // saturating update of the entry
  logic signed [63:0] old_r, old_g, old_b, new_r, new_g, new_b;
  logic signed [31:0] old_w, new_w;
  assign old_r = vld_rd_q ? acc_rdata[223:160] : '0;
  assign old_g = vld_rd_q ? acc_rdata[159:96]  : '0;
  assign old_b = vld_rd_q ? acc_rdata[95:32]   : '0;
  assign old_w = vld_rd_q ? acc_rdata[31:0]    : '0;
  assign new_r = sat_add64(old_r, con_q[0]);
  assign new_g = sat_add64(old_g, con_q[1]);
  assign new_b = sat_add64(old_b, con_q[2]);
  assign new_w = sat_add32(old_w, 32'(tval));
  assign acc_wdata = {new_r, new_g, new_b, new_w};

  logic nonempty, x_more, y_more;
  assign nonempty = (xa_c < xb_c) && (ya_c < yb_c);
  assign x_more   = (x_q + 16'sd1) < xb_q;
  assign y_more   = (y_q + 16'sd1) < yb_q;

  logic res_load;
  assign res_load = (state_q == S_RDOUT) && (!res_vld_q || res_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc_ok) begin
          if (smp_i.mode == MODE_ADD) begin
            state_d = S_LUM;
          end else if (smp_i.mode == MODE_READ) begin
            state_d = S_RDOUT;
          end
        end
      end
      S_RDOUT: begin
        if (res_load) begin
          state_d = S_IDLE;
        end
      end
      S_LUM: begin
        if (k_q == 2'd2) begin
          state_d = S_CHK;
        end
      end
      S_CHK:  state_d = clamp ? S_CMUL : S_LW;
      S_CMUL: state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == 5'd31) begin
          state_d = (k_q == 2'd2) ? S_LW : S_CMUL;
        end
      end
      S_LW: begin
        if (k_q == 2'd2) begin
          state_d = S_BND;
        end
      end
      S_BND: state_d = nonempty ? S_ROW : S_IDLE;
      S_ROW: state_d = S_COL;
      S_COL: state_d = S_RD;
      S_RD:  state_d = S_MUL;
      S_MUL: begin
        if (k_q == 2'd2) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        if (x_more) begin
          state_d = S_COL;
        end else if (y_more) begin
          state_d = S_ROW;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // channel and divider counters
  always_comb begin
    k_d   = k_q;
    cnt_d = 5'd0;
    case (state_q)
      S_LUM, S_LW, S_MUL: k_d = (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
      S_DIV: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          k_d = (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
        end
      end
      default: k_d = k_q;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      k_q       <= 2'd0;
      cnt_q     <= 5'd0;
      vld_q     <= '0;
      res_vld_q <= 1'b0;
      x0_q      <= 12'd0;
      y0_q      <= 12'd0;
      x1_q      <= 12'd16;
      y1_q      <= 12'd16;
      rad_q     <= 32'h0800_1800;
      inv_q     <= 32'h0800_1800;
      maxlum_q  <= '1;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      if (acc_ok && (smp_i.mode == MODE_CLEAR)) begin
        vld_q[smp_i.pixel_index] <= 1'b0;
      end
      if (acc_we) begin
        vld_q[pix_q] <= 1'b1;
      end
      if (res_load) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_TILE_X0: x0_q     <= cfg_i.data[11:0];
          CFG_TILE_Y0: y0_q     <= cfg_i.data[11:0];
          CFG_TILE_X1: x1_q     <= cfg_i.data[11:0];
          CFG_TILE_Y1: y1_q     <= cfg_i.data[11:0];
          CFG_RADIUS:  rad_q    <= cfg_i.data;
          CFG_INV_RAD: inv_q    <= cfg_i.data;
          CFG_MAX_LUM: maxlum_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (acc_ok) begin
          sx_q      <= smp_i.sample_x;
          sy_q      <= smp_i.sample_y;
          c_q[0]    <= smp_i.red;
          c_q[1]    <= smp_i.green;
          c_q[2]    <= smp_i.blue;
          wgt_q     <= smp_i.sample_weight;
          lum_acc_q <= '0;
          vld_rd_q  <= vld_q[smp_i.pixel_index];
        end
      end
      S_RDOUT: begin
        if (res_load) begin
          res_r_q <= old_r;
          res_g_q <= old_g;
          res_b_q <= old_b;
          res_w_q <= old_w;
        end
      end
      S_LUM: lum_acc_q <= lum_acc_q + mul_p[47:0];
      S_CMUL: begin
        rem_q <= mul_p[63:32];
        quo_q <= mul_p[31:0];
      end
      S_DIV: begin
        rem_q <= div_rem;
        quo_q <= div_quo;
        if (cnt_q == 5'd31) begin
          c_q[k_q] <= div_quo;
        end
      end
      S_LW: lw_q[k_q] <= mul_p;
      S_BND: begin
        pdx_q <= pdx_c;
        pdy_q <= pdy_c;
        xa_q  <= xa_c;
        xb_q  <= xb_c;
        ya_q  <= ya_c;
        yb_q  <= yb_c;
        y_q   <= ya_c;
      end
      S_ROW: begin
        row_q <= sl_idx;
        x_q   <= xa_q;
      end
      S_COL: begin
        col_q <= sl_idx;
        pix_q <= pix_tmp[ADDR_W-1:0];
      end
      S_RD:  vld_rd_q <= vld_q[pix_q];
      S_MUL: con_q[k_q] <= con_c;
      S_ADD: begin
        if (x_more) begin
          x_q <= x_q + 16'sd1;
        end else if (y_more) begin
          y_q <= y_q + 16'sd1;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid      = res_vld_q;
  assign res_o.sum_red    = res_r_q;
  assign res_o.sum_green  = res_g_q;
  assign res_o.sum_blue   = res_b_q;
  assign res_o.weight_sum = res_w_q;

  // divider always runs its full 32 steps
  `ASSERT_IMP(a_div_len, (state_q == S_DIV) && (state_d != S_DIV), cnt_q == 5'd31,
              "divider left early")
  // walk stays inside the clipped footprint
  `ASSERT_IMP(a_walk_in, state_q == S_COL,
              (x_q >= xa_q) && (x_q < xb_q) && (y_q >= ya_q) && (y_q < yb_q),
              "pixel walk outside footprint")
  // a pending result is never overwritten
  `ASSERT_NXT(a_res_keep, res_vld_q && !res_o.ready && (state_q == S_RDOUT),
              state_q == S_RDOUT, "pending result overwritten")

endmodule

`default_nettype wire
